>>> rtl/bcse_pkg.sv
// Shared types and codes for the byte command schedule engine.
// Holds the item and result beat structs, request, kind and status codes.
// No dependencies.
package bcse_pkg;

	localparam int LEN_W = 13;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_CMD    = 2'd1;
	localparam logic [1:0] REQ_FINISH = 2'd2;
	localparam logic [1:0] REQ_READ   = 2'd3;

	localparam logic [7:0] KIND_COPY = 8'd0;
	localparam logic [7:0] KIND_FILL = 8'd1;
	localparam logic [7:0] KIND_ADD  = 8'd2;
	localparam logic [7:0] KIND_XOR  = 8'd3;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_OFFSET = 3'd1;
	localparam logic [2:0] ST_SINK   = 3'd2;
	localparam logic [2:0] ST_SOURCE = 3'd3;
	localparam logic [2:0] ST_KIND   = 3'd4;
	localparam logic [2:0] ST_SHORT  = 3'd5;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [11:0]      byte_index;
		logic [7:0]       byte_data;
		logic [LEN_W-1:0] cmd_offset;
		logic [LEN_W-1:0] cmd_length;
		logic [LEN_W-1:0] cmd_source_offset;
		logic [7:0]       cmd_value;
		logic [7:0]       cmd_kind;
	} item_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [7:0]       read_byte;
		logic [LEN_W-1:0] cursor_now;
	} result_t;

	typedef struct packed {
		logic       fail;
		logic [2:0] code;
	} chk_t;

endpackage

>>> rtl/bcse_check.sv
// Command admission check: cursor, sink bounds, then source bounds and kind (not for a fill).
// Depends on bcse_pkg.
module bcse_check (
	input  logic [bcse_pkg::LEN_W-1:0] cursor,
	input  logic [bcse_pkg::LEN_W-1:0] snk_limit,
	input  logic [bcse_pkg::LEN_W-1:0] src_limit,
	input  logic [bcse_pkg::LEN_W-1:0] offset,
	input  logic [bcse_pkg::LEN_W-1:0] length,
	input  logic [bcse_pkg::LEN_W-1:0] src_start,
	input  logic [7:0]                 kind,
	output bcse_pkg::chk_t             chk
);
	import bcse_pkg::*;

	logic [LEN_W:0] sink_end;
	logic [LEN_W:0] source_end;
	logic           kind_ok;

	assign sink_end   = {1'b0, offset} + {1'b0, length};
	assign source_end = {1'b0, src_start} + {1'b0, length};
	assign kind_ok    = (kind == KIND_COPY) || (kind == KIND_ADD) || (kind == KIND_XOR);

	// Order decides: the first failing test names the error.
	always_comb begin
		chk.fail = 1'b1;
		chk.code = ST_OK;
		priority if (offset != cursor) begin
			chk.code = ST_OFFSET;
		end else if (sink_end > {1'b0, snk_limit}) begin
			chk.code = ST_SINK;
		end else if (kind == KIND_FILL) begin
			chk.fail = 1'b0;
		end else if (source_end > {1'b0, src_limit}) begin
			chk.code = ST_SOURCE;
		end else if (!kind_ok) begin
			chk.code = ST_KIND;
		end else begin
			chk.fail = 1'b0;
		end
	end

endmodule

>>> rtl/bcse_byte_alu.sv
// Shared byte unit: one sink byte per cycle from a source byte and the constant.
// Depends on bcse_pkg.
module bcse_byte_alu (
	input  logic [7:0] kind,
	input  logic [7:0] value,
	input  logic [7:0] src_byte,
	output logic [7:0] sink_byte
);
	import bcse_pkg::*;

	always_comb begin
		unique case (kind)
			KIND_FILL: sink_byte = value;
			KIND_ADD:  sink_byte = src_byte + value;
			KIND_XOR:  sink_byte = src_byte ^ value;
			default:   sink_byte = src_byte;
		endcase
	end

endmodule

>>> rtl/byte_command_schedule_engine_core.sv
// channel  | dir | handshake                  | beat
// item     | in  | item_valid / item_stall    | bcse_pkg::item_t
// result   | out | result_valid / result_stall| bcse_pkg::result_t
// cfg      | in  | cfg_we (no wait)           | cfg_index, cfg_data
//
// A passing command of L bytes makes one source read (none for a fill) and one sink
// write per byte through a one-stage read/modify/write pipe, waits for the last write,
// then picks up the result. A rejected command, load, finish and read go straight to
// the result state; a new item is taken only once the previous one has left it.
// Reset clears cursor, error, config and control; store contents are kept.
// A stalled result holds in the output register; one more item is taken and waits.
// Top level: owns both byte stores and the sequencer; uses bcse_check and
// bcse_byte_alu. Depends on bcse_pkg.
module byte_command_schedule_engine_core #(
	parameter int SINK_DEPTH   = 4096,
	parameter int SOURCE_DEPTH = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  bcse_pkg::item_t              item,
	output logic                         result_valid,
	input  logic                         result_stall,
	output bcse_pkg::result_t            result,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [bcse_pkg::LEN_W-1:0]   cfg_data
);
	import bcse_pkg::*;

	localparam int SAW = $clog2(SINK_DEPTH);
	localparam int RAW = $clog2(SOURCE_DEPTH);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_RUN    = 2'd1;
	localparam logic [1:0] S_RESULT = 2'd2;

	localparam logic CFG_SINK_LEN   = 1'b0;
	localparam logic CFG_SOURCE_LEN = 1'b1;

	logic [7:0] source_mem [SOURCE_DEPTH];
	logic [7:0] sink_mem   [SINK_DEPTH];

	logic [1:0]       state_q;
	logic [LEN_W-1:0] snk_limit_q;
	logic [LEN_W-1:0] src_limit_q;
	logic [LEN_W-1:0] cursor_q;
	logic [2:0]       err_q;
	logic [2:0]       res_status_q;
	logic             res_rd_q;
	logic [7:0]       sink_rd_q;
	logic [LEN_W-1:0] rem_q;
	logic [RAW-1:0]   src_addr_q;
	logic [SAW-1:0]   dst_addr_q;
	logic [7:0]       kind_q;
	logic [7:0]       value_q;
	logic             v_s1;
	logic [SAW-1:0]   dst_s1;
	logic [7:0]       src_s1;
	logic             out_valid_q;
	result_t          out_q;

	logic [LEN_W-1:0] sink_eff;
	logic [LEN_W-1:0] source_eff;
	logic             accept;
	logic             src_idx_ok;
	logic             sink_idx_ok;
	logic             issue;
	logic             out_free;
	chk_t             chk;
	logic [7:0]       alu_byte;

	assign sink_eff   = (32'(snk_limit_q) > SINK_DEPTH) ? LEN_W'(SINK_DEPTH) : snk_limit_q;
	assign source_eff = (32'(src_limit_q) > SOURCE_DEPTH) ? LEN_W'(SOURCE_DEPTH)
		: src_limit_q;

	assign item_stall  = (state_q != S_IDLE);
	assign accept      = item_valid && !item_stall;
	assign src_idx_ok  = 32'(item.byte_index) < SOURCE_DEPTH;
	assign sink_idx_ok = 32'(item.byte_index) < SINK_DEPTH;
	assign issue       = (state_q == S_RUN) && (rem_q != '0);
	assign out_free    = !out_valid_q || !result_stall;

	assign result_valid = out_valid_q;
	assign result       = out_q;

	bcse_check u_check (
		.cursor    (cursor_q),
		.snk_limit (sink_eff),
		.src_limit (source_eff),
		.offset    (item.cmd_offset),
		.length    (item.cmd_length),
		.src_start (item.cmd_source_offset),
		.kind      (item.cmd_kind),
		.chk       (chk)
	);

	bcse_byte_alu u_alu (
		.kind      (kind_q),
		.value     (value_q),
		.src_byte  (src_s1),
		.sink_byte (alu_byte)
	);

	// Source store: written by a load item, read one byte per cycle while a copy, add or xor runs.
	always_ff @(posedge clk) begin
		if (accept && item.req_type == REQ_LOAD && src_idx_ok) begin
			source_mem[RAW'(item.byte_index)] <= item.byte_data;
		end
		if (issue && kind_q != KIND_FILL) begin
			src_s1 <= source_mem[src_addr_q];
		end
	end

	// Sink store: written from the pipe, read on a read item.
	always_ff @(posedge clk) begin
		if (v_s1) begin
			sink_mem[dst_s1] <= alu_byte;
		end
		if (accept && item.req_type == REQ_READ && sink_idx_ok) begin
			sink_rd_q <= sink_mem[SAW'(item.byte_index)];
		end
	end

	// Payload registers for the running command and the pending result.
	always_ff @(posedge clk) begin
		if (accept) begin
			src_addr_q <= RAW'(item.cmd_source_offset);
			dst_addr_q <= SAW'(item.cmd_offset);
			kind_q     <= item.cmd_kind;
			value_q    <= item.cmd_value;
			res_rd_q   <= (item.req_type == REQ_READ) && sink_idx_ok;
		end else if (issue) begin
			src_addr_q <= src_addr_q + 1'b1;
			dst_addr_q <= dst_addr_q + 1'b1;
		end
		if (issue) begin
			dst_s1 <= dst_addr_q;
		end
		if (state_q == S_RESULT && out_free) begin
			out_q.status     <= res_status_q;
			out_q.read_byte  <= res_rd_q ? sink_rd_q : 8'd0;
			out_q.cursor_now <= cursor_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			snk_limit_q  <= '0;
			src_limit_q  <= '0;
			cursor_q     <= '0;
			err_q        <= ST_OK;
			res_status_q <= ST_OK;
			rem_q        <= '0;
			v_s1         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SINK_LEN:   snk_limit_q <= cfg_data;
					CFG_SOURCE_LEN: src_limit_q <= cfg_data;
					default:        snk_limit_q <= snk_limit_q;
				endcase
			end

			// load a new beat, or drop the one just taken
			if (state_q == S_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end

			v_s1 <= issue;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q      <= S_RESULT;
						res_status_q <= err_q;
						unique case (item.req_type)
							REQ_CMD: begin
								if (err_q == ST_OK) begin
									if (chk.fail) begin
										err_q        <= chk.code;
										res_status_q <= chk.code;
									end else begin
										cursor_q <= cursor_q + item.cmd_length;
										rem_q    <= item.cmd_length;
										state_q  <= S_RUN;
									end
								end
							end
							REQ_FINISH: begin
								if (err_q == ST_OK && cursor_q != sink_eff) begin
									res_status_q <= ST_SHORT;
								end
								cursor_q <= '0;
								err_q    <= ST_OK;
							end
							default: begin
								res_status_q <= err_q;
							end
						endcase
					end
				end
				S_RUN: begin
					if (issue) begin
						rem_q <= rem_q - 1'b1;
					end else if (!v_s1) begin
						// last byte written, pipe empty
						res_status_q <= ST_OK;
						state_q      <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/bcse_checker.sv
// Port-level checker for the byte command schedule engine, bound to the top.
// Depends on bcse_pkg and byte_command_schedule_engine_core.
module bcse_props (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input logic              result_valid,
	input logic              result_stall,
	input bcse_pkg::result_t result
);
	import bcse_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item taken while previous item still in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.status == ST_OK || result.status == ST_OFFSET ||
			result.status == ST_SINK || result.status == ST_SOURCE ||
			result.status == ST_KIND || result.status == ST_SHORT))
		else $error("result status code out of range");

	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result beat with no item in work");

endmodule

bind byte_command_schedule_engine_core bcse_props u_bcse_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

>>> sim/bcse_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the byte command schedule engine: keeps its own byte stores,
// cursor, sticky error and length registers, and checks each result beat in order.
// Depends on bcse_pkg.
module bcse_checker #(
	parameter logic SINK_LEN_REG   = 1'b0,
	parameter logic SOURCE_LEN_REG = 1'b1,
	parameter int   SINK_DEPTH     = 4096,
	parameter int   SOURCE_DEPTH   = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	input  logic                       item_stall,
	input  bcse_pkg::item_t            item,
	input  logic                       result_valid,
	input  logic                       result_stall,
	input  bcse_pkg::result_t          result,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [bcse_pkg::LEN_W-1:0] cfg_data,
	output int                         fails,
	output int                         pending,
	output int                         checked
);
	import bcse_pkg::*;

	logic [7:0]       src_bytes [SOURCE_DEPTH];
	logic [7:0]       snk_bytes [SINK_DEPTH];
	logic [LEN_W-1:0] wr_pos;
	logic [LEN_W-1:0] snk_limit_reg;
	logic [LEN_W-1:0] src_len_reg;
	logic [2:0]       held_err;
	result_t          owed [$];
	result_t          want;
	int               misses;
	int               seen;

	// lengths above the store depth saturate
	function automatic int sink_span();
		return (int'(snk_limit_reg) > SINK_DEPTH) ? SINK_DEPTH : int'(snk_limit_reg);
	endfunction

	function automatic logic [2:0] apply_cmd(item_t it);
		int         slen;
		int         rlen;
		int         off;
		int         len;
		int         soff;
		logic [7:0] b;
		slen = sink_span();
		rlen = (int'(src_len_reg) > SOURCE_DEPTH) ? SOURCE_DEPTH : int'(src_len_reg);
		off  = int'(it.cmd_offset);
		len  = int'(it.cmd_length);
		soff = int'(it.cmd_source_offset);
		if (off != int'(wr_pos))
			return ST_OFFSET;
		if (off > slen || len > slen - off)
			return ST_SINK;
		// a fill never looks at the source range
		if (it.cmd_kind != KIND_FILL) begin
			if (soff > rlen || len > rlen - soff)
				return ST_SOURCE;
			if (it.cmd_kind != KIND_COPY && it.cmd_kind != KIND_ADD && it.cmd_kind != KIND_XOR)
				return ST_KIND;
		end
		for (int j = 0; j < len; j++) begin
			if (it.cmd_kind == KIND_FILL) begin
				b = it.cmd_value;
			end else begin
				b = src_bytes[soff + j];
				if (it.cmd_kind == KIND_ADD)
					b = b + it.cmd_value;
				else if (it.cmd_kind == KIND_XOR)
					b = b ^ it.cmd_value;
			end
			snk_bytes[off + j] = b;
		end
		wr_pos = LEN_W'(int'(wr_pos) + len);
		return ST_OK;
	endfunction

	function automatic result_t engine_answer(item_t it);
		result_t r;
		r.status    = held_err;
		r.read_byte = '0;
		case (it.req_type)
			REQ_LOAD: begin
				src_bytes[it.byte_index] = it.byte_data;
			end
			REQ_CMD: begin
				if (held_err == ST_OK)
					held_err = apply_cmd(it);
				r.status = held_err;
			end
			REQ_FINISH: begin
				if (held_err == ST_OK)
					r.status = (int'(wr_pos) != sink_span()) ? ST_SHORT : ST_OK;
				wr_pos   = '0;
				held_err = ST_OK;
			end
			REQ_READ: begin
				r.read_byte = snk_bytes[it.byte_index];
			end
		endcase
		r.cursor_now = wr_pos;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos        = '0;
			held_err      = ST_OK;
			snk_limit_reg = '0;
			src_len_reg   = '0;
			owed.delete();
			misses       = 0;
			seen         = 0;
			fails   <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == SINK_LEN_REG)
					snk_limit_reg = cfg_data;
				else if (cfg_index == SOURCE_LEN_REG)
					src_len_reg = cfg_data;
			end
			// compare before pushing: a beat accepted now belongs to an older item
			if (result_valid && !result_stall) begin
				if (owed.size() == 0) begin
					$display("%0t: result beat with nothing owed: status %0d read %02h cursor %0d",
						$time, result.status, result.read_byte, result.cursor_now);
					misses++;
				end else begin
					want = owed.pop_front();
					seen++;
					if (result.status !== want.status || result.read_byte !== want.read_byte ||
							result.cursor_now !== want.cursor_now) begin
						$display("%0t: expected status %0d read %02h cursor %0d, got status %0d read %02h cursor %0d",
							$time, want.status, want.read_byte, want.cursor_now,
							result.status, result.read_byte, result.cursor_now);
						misses++;
					end
				end
			end
			if (item_valid && !item_stall)
				owed.push_back(engine_answer(item));
			fails   <= misses;
			pending <= owed.size();
			checked <= seen;
		end
	end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Top of the byte command schedule engine bench: clock, reset, item and register
// stimulus, random idling on both channels, watchdog and verdict.
// Depends on bcse_pkg, bcse_checker and the engine RTL.
module testbench;
	import bcse_pkg::*;

	localparam logic SINK_LEN_REG   = 1'b0;
	localparam logic SOURCE_LEN_REG = 1'b1;
	localparam int   DEPTH          = 4096;
	localparam int   LEN_MAX        = 8191;
	localparam int   SQUEEZE_CYCLES = 300;
	localparam int   IDLE_LIMIT     = 20000;
	localparam int   RANDOM_BEATS   = 80;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             item_valid   = 1'b0;
	logic             item_stall;
	item_t            item         = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	result_t          result;
	logic             cfg_we       = 1'b0;
	logic             cfg_index    = 1'b0;
	logic [LEN_W-1:0] cfg_data     = '0;

	int   fails;
	int   pending;
	int   checked;
	int   beats_sent   = 0;
	int   settings     = 0;
	int   quiet_cycles = 0;
	int   gap_odds     = 0;
	int   stall_odds   = 0;
	logic squeeze      = 1'b0;
	int   src_top      = 0;  // source bytes below this index have all been loaded
	int   sink_cfg     = 0;
	int   src_cfg      = 0;

	byte_command_schedule_engine_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	bcse_checker #(
		.SINK_LEN_REG   (SINK_LEN_REG),
		.SOURCE_LEN_REG (SOURCE_LEN_REG)
	) score (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fails        (fails),
		.pending      (pending),
		.checked      (checked)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic item_t noise_item();
		item_t it;
		it.req_type          = REQ_LOAD;
		it.byte_index        = 12'($urandom_range(0, DEPTH - 1));
		it.byte_data         = 8'($urandom_range(0, 255));
		it.cmd_offset        = LEN_W'($urandom_range(0, LEN_MAX));
		it.cmd_length        = LEN_W'($urandom_range(0, LEN_MAX));
		it.cmd_source_offset = LEN_W'($urandom_range(0, LEN_MAX));
		it.cmd_value         = 8'($urandom_range(0, 255));
		it.cmd_kind          = 8'($urandom_range(0, 255));
		return it;
	endfunction

	// valid stays high after the beat; the next call either replaces it or drops it
	task automatic send(item_t it);
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		beats_sent++;
	endtask

	task automatic configure(int sink, int source);
		item_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		cfg_we    <= 1'b1;
		cfg_index <= SINK_LEN_REG;
		cfg_data  <= LEN_W'(sink);
		@(posedge clk);
		cfg_index <= SOURCE_LEN_REG;
		cfg_data  <= LEN_W'(source);
		@(posedge clk);
		cfg_we   <= 1'b0;
		sink_cfg = sink;
		src_cfg  = source;
		settings++;
	endtask

	task automatic load_src(int idx, logic [7:0] data);
		item_t it;
		it            = noise_item();
		it.req_type   = REQ_LOAD;
		it.byte_index = 12'(idx);
		it.byte_data  = data;
		send(it);
		if (idx == src_top)
			src_top++;
	endtask

	task automatic grow_src(int n);
		repeat (n) begin
			if (src_top < DEPTH)
				load_src(src_top, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic read_sink(int idx);
		item_t it;
		it            = noise_item();
		it.req_type   = REQ_READ;
		it.byte_index = 12'(idx);
		send(it);
	endtask

	task automatic finish_sched();
		item_t it;
		it          = noise_item();
		it.req_type = REQ_FINISH;
		send(it);
	endtask

	// a copy, add or xor that could pass the bounds check over unloaded source
	// bytes is turned into a fill
	task automatic issue_cmd(int off, int len, int soff, logic [7:0] val, logic [7:0] kind);
		item_t it;
		int    eff;
		eff = (src_cfg > DEPTH) ? DEPTH : src_cfg;
		if ((kind == KIND_COPY || kind == KIND_ADD || kind == KIND_XOR) && len != 0 &&
				soff + len > src_top && soff + len <= eff)
			kind = KIND_FILL;
		it                   = noise_item();
		it.req_type          = REQ_CMD;
		it.cmd_offset        = LEN_W'(off);
		it.cmd_length        = LEN_W'(len);
		it.cmd_source_offset = LEN_W'(soff);
		it.cmd_value         = val;
		it.cmd_kind          = kind;
		send(it);
	endtask

	// commands that tile the sink from the cursor, then finish; a mangled
	// schedule gets a broken field now and then or stops early
	task automatic play_schedule(bit mangle);
		int         slen;
		int         lim;
		int         c;
		int         room;
		int         len;
		int         off;
		int         soff;
		logic [7:0] kind;
		slen = (sink_cfg > DEPTH) ? DEPTH : sink_cfg;
		lim  = (src_cfg > DEPTH) ? DEPTH : src_cfg;
		lim  = (src_top < lim) ? src_top : lim;
		c    = 0;
		while (c < slen) begin
			room = slen - c;
			if (room > 64)
				len = $urandom_range(1, room);
			else
				len = $urandom_range(0, (room > 12) ? 12 : room);
			kind = 8'($urandom_range(0, 3));
			soff = $urandom_range(0, LEN_MAX);
			if (kind != KIND_FILL) begin
				if (lim >= len)
					soff = $urandom_range(0, lim - len);
				else
					kind = KIND_FILL;
			end
			off = c;
			c   = c + len;
			if (mangle && $urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 3))
					0: off = $urandom_range(0, LEN_MAX);
					1: len = $urandom_range(0, LEN_MAX);
					2: soff = $urandom_range(0, LEN_MAX);
					default: kind = 8'($urandom_range(4, 255));
				endcase
			end
			issue_cmd(off, len, soff, 8'($urandom_range(0, 255)), kind);
			if ($urandom_range(0, 5) == 0) begin
				if ($urandom_range(0, 1) == 0)
					read_sink($urandom_range(0, DEPTH - 1));
				else
					grow_src(1);
			end
			if (mangle && $urandom_range(0, 7) == 0)
				break;
		end
		finish_sched();
		repeat ($urandom_range(0, 3)) read_sink($urandom_range(0, DEPTH - 1));
	endtask

	function automatic int pick_odds();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 3;
			default: return 8;
		endcase
	endfunction

	// result side: random stall bursts, plus one long hold-off while items keep coming
	initial begin
		logic squeezed;
		squeezed = 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze && !squeezed) begin
				squeezed = 1'b1;
				result_stall <= 1'b1;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
			end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles, %0d results owed",
				$time, IDLE_LIMIT, pending);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int start;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole sink once so that any later read hits a written byte
		configure(DEPTH, 0);
		issue_cmd(0, DEPTH, 0, 8'hA5, KIND_FILL);
		finish_sched();
		read_sink(DEPTH - 1);
		grow_src(24);
		load_src(DEPTH - 1, 8'hFF);

		configure(16, 24);
		issue_cmd(0, 4, 0, 8'h00, KIND_COPY);
		issue_cmd(4, 4, 4, 8'hFF, KIND_ADD);
		issue_cmd(8, 4, 8, 8'h5A, KIND_XOR);
		issue_cmd(12, 0, 0, 8'h00, KIND_FILL);
		issue_cmd(12, 4, 20, 8'hFF, KIND_FILL);
		finish_sched();
		read_sink(5);
		// offset off the cursor sticks; the next good command is ignored
		issue_cmd(5, 2, 0, 8'h00, KIND_COPY);
		issue_cmd(0, 2, 0, 8'h00, KIND_COPY);
		load_src(30, 8'h3C);
		finish_sched();
		issue_cmd(0, 17, 0, 8'h11, KIND_FILL);
		finish_sched();
		issue_cmd(0, 4, 22, 8'h00, KIND_COPY);
		finish_sched();
		// bad kind over an out-of-range source reports the source error
		issue_cmd(0, 2, 30, 8'h00, 8'hFF);
		finish_sched();
		issue_cmd(0, 2, 0, 8'h00, 8'h80);
		finish_sched();
		issue_cmd(0, 4, 0, 8'h77, KIND_XOR);
		finish_sched();

		// both lengths past the depth: saturated
		configure(LEN_MAX, LEN_MAX);
		issue_cmd(0, LEN_MAX, 0, 8'h00, KIND_FILL);
		finish_sched();
		issue_cmd(0, 4, LEN_MAX, 8'h00, KIND_COPY);
		finish_sched();
		issue_cmd(0, 4, 0, 8'h81, KIND_ADD);
		finish_sched();

		configure(0, 0);
		issue_cmd(0, 0, 0, 8'h00, KIND_COPY);
		finish_sched();

		squeeze <= 1'b1;
		start = beats_sent;
		while (beats_sent - start < RANDOM_BEATS) begin
			if (beats_sent - start > RANDOM_BEATS - 25) begin
				gap_odds   = 0;
				stall_odds = 0;
			end else begin
				gap_odds   = pick_odds();
				stall_odds = pick_odds();
			end
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 11))
					0: sink_cfg = 0;
					1: sink_cfg = $urandom_range(DEPTH, LEN_MAX);
					default: sink_cfg = $urandom_range(1, 40);
				endcase
				case ($urandom_range(0, 7))
					0: src_cfg = $urandom_range(DEPTH, LEN_MAX);
					1: src_cfg = 0;
					default: src_cfg = $urandom_range(0, src_top + 8);
				endcase
				configure(sink_cfg, src_cfg);
			end
			grow_src($urandom_range(0, 4));
			play_schedule($urandom_range(0, 2) == 0);
		end

		item_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (16) @(posedge clk);
		$display("Sent %0d item beats over %0d register settings; %0d results compared.",
			beats_sent, settings, checked);
		$display("Loaded %0d leading source bytes; result side held off once for %0d cycles.",
			src_top, SQUEEZE_CYCLES);
		if (fails == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> byte_command_schedule_engine_core.f
rtl/bcse_pkg.sv
rtl/bcse_check.sv
rtl/bcse_byte_alu.sv
rtl/byte_command_schedule_engine_core.sv
rtl/bcse_checker.sv
sim/bcse_checker.sv
sim/testbench.sv
